FILE: sv/tcw_pkg.sv
`timescale 1ns / 1ps
// tcw_pkg: shared types and constants of the text console writer
// depends on nothing; used by tcw_ctrl, tcw_dp, the top level and the checker

package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // field widths
    localparam int OP_W    = 3;
    localparam int CHAR_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int COLOR_W = 4;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 40;

    // opcodes
    localparam logic [OP_W-1:0] OP_PUT_CHAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_NEWLINE    = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_CURSOR = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd4;

    // configuration register indexes
    localparam logic CFG_FOREGROUND = 1'b0;
    localparam logic CFG_BACKGROUND = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    localparam logic [CHAR_W-1:0] LINE_FEED  = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_MOVE,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic move;
        logic fill;
        logic clear;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scroll;
        logic is_clear;
        logic is_read;
        logic move_last;
        logic scan_last;
    } t_status;

endpackage

FILE: sv/tcw_ctrl.sv
`timescale 1ns / 1ps
// tcw_ctrl: sequencer of the text console writer
// depends on tcw_pkg; drives tcw_dp through t_cmd, watches t_status

module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  tcw_pkg::t_status i_status,
    output tcw_pkg::t_cmd    o_cmd
);

    tcw_pkg::t_state r_state, n_state;
    logic r_out_valid;
    logic w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = tcw_pkg::ST_EXEC;
            end
            tcw_pkg::ST_EXEC: begin
                if (i_status.need_scroll)   n_state = tcw_pkg::ST_MOVE;
                else if (i_status.is_clear) n_state = tcw_pkg::ST_CLEAR;
                else if (i_status.is_read)  n_state = tcw_pkg::ST_READ;
                else if (w_out_free)        n_state = tcw_pkg::ST_IDLE;
                else                        n_state = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_READ: begin
                n_state = w_out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_MOVE: begin
                if (i_status.move_last) n_state = tcw_pkg::ST_FILL;
            end
            tcw_pkg::ST_FILL: begin
                if (i_status.scan_last) n_state = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_CLEAR: begin
                if (i_status.scan_last) n_state = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE: begin
                if (w_out_free) n_state = tcw_pkg::ST_IDLE;
            end
            default: n_state = tcw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            tcw_pkg::ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.latch = i_s_tvalid;
            end
            tcw_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                o_cmd.load = !i_status.need_scroll && !i_status.is_clear
                             && !i_status.is_read && w_out_free;
            end
            tcw_pkg::ST_READ:  o_cmd.load  = w_out_free;
            tcw_pkg::ST_MOVE:  o_cmd.move  = 1'b1;
            tcw_pkg::ST_FILL:  o_cmd.fill  = 1'b1;
            tcw_pkg::ST_CLEAR: o_cmd.clear = 1'b1;
            tcw_pkg::ST_DONE:  o_cmd.load  = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load)      r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

FILE: sv/tcw_dp.sv
`timescale 1ns / 1ps
// tcw_dp: datapath of the text console writer: item, cursor, colors, screen store
// depends on tcw_pkg; commanded by tcw_ctrl

module tcw_dp #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_addr,
    input  logic [tcw_pkg::COLOR_W-1:0]  i_cfg_wdata,
    input  logic [tcw_pkg::IN_W-1:0]     i_s_tdata,
    input  tcw_pkg::t_cmd                i_cmd,
    output tcw_pkg::t_status             o_status,
    output logic [tcw_pkg::OUT_W-1:0]    o_m_tdata
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] MOVE_LAST = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [tcw_pkg::COL_W:0]   COL_LIM_X = (tcw_pkg::COL_W + 1)'(COLUMNS);
    localparam logic [tcw_pkg::COL_W-1:0] COL_LIM   = tcw_pkg::COL_W'(COLUMNS);
    localparam logic [tcw_pkg::ROW_W-1:0] ROW_LIM   = tcw_pkg::ROW_W'(ROWS);
    localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST  = tcw_pkg::ROW_W'(ROWS - 1);

    // row-major linear position
    function automatic logic [15:0] lin_pos(input logic [tcw_pkg::ROW_W-1:0] row,
                                            input logic [tcw_pkg::COL_W-1:0] col);
        lin_pos = 16'(row) * 16'(COLUMNS) + 16'(col);
    endfunction

    logic [tcw_pkg::CELL_W-1:0] r_mem [CELLS];

    logic [tcw_pkg::OP_W-1:0]    r_op;
    logic [tcw_pkg::CHAR_W-1:0]  r_ch;
    logic [tcw_pkg::COL_W-1:0]   r_tcol;
    logic [tcw_pkg::ROW_W-1:0]   r_trow;
    logic                        r_ovr;
    logic [tcw_pkg::COLOR_W-1:0] r_ofg, r_obg;
    logic [tcw_pkg::COLOR_W-1:0] r_fg, r_bg;
    logic [tcw_pkg::COL_W-1:0]   r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0]   r_row, n_row;
    logic                        r_scrolled, n_scrolled;
    logic [ADDR_W-1:0]           r_idx;
    logic                        r_mv_valid;
    logic [ADDR_W-1:0]           r_mv_addr;
    logic [tcw_pkg::CELL_W-1:0]  r_rd_data;
    logic [tcw_pkg::OUT_W-1:0]   r_out;

    logic [7:0]                  w_attr;
    logic [tcw_pkg::CELL_W-1:0]  w_blank;
    logic [tcw_pkg::COL_W:0]     w_col_inc;
    logic                        w_wrap, w_at_last, w_lf, w_target_ok;
    logic [15:0]                 w_cur_lin, w_tgt_lin, w_out_lin;
    logic                        w_we, w_re;
    logic [ADDR_W-1:0]           w_wa, w_ra;
    logic [tcw_pkg::CELL_W-1:0]  w_wd, w_cell;

    assign w_attr  = r_ovr ? {r_obg, r_ofg} : {r_bg, r_fg};
    assign w_blank = {w_attr, tcw_pkg::BLANK_CHAR};

    assign w_col_inc   = {1'b0, r_col} + 8'd1;
    assign w_wrap      = w_col_inc >= COL_LIM_X;
    assign w_at_last   = r_row >= ROW_LAST;
    assign w_lf        = (r_op == tcw_pkg::OP_NEWLINE) ||
                         ((r_op == tcw_pkg::OP_PUT_CHAR) &&
                          ((r_ch == tcw_pkg::LINE_FEED) || w_wrap));
    assign w_target_ok = (r_tcol < COL_LIM) && (r_trow < ROW_LIM);
    assign w_cur_lin   = lin_pos(r_row, r_col);
    assign w_tgt_lin   = lin_pos(r_trow, r_tcol);

    assign o_status.need_scroll = w_lf && w_at_last;
    assign o_status.is_clear    = r_op == tcw_pkg::OP_CLEAR;
    assign o_status.is_read     = r_op == tcw_pkg::OP_READ_CELL;
    assign o_status.move_last   = r_idx == MOVE_LAST;
    assign o_status.scan_last   = r_idx == CELL_LAST;

    // cursor update
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.exec) begin
            if (w_lf) begin
                n_col = '0;
                n_row = w_at_last ? ROW_LAST : r_row + 5'd1;
            end else begin
                case (r_op)
                    tcw_pkg::OP_PUT_CHAR: n_col = w_col_inc[tcw_pkg::COL_W-1:0];
                    tcw_pkg::OP_SET_CURSOR: begin
                        if (w_target_ok) begin
                            n_col = r_tcol;
                            n_row = r_trow;
                        end
                    end
                    tcw_pkg::OP_CLEAR: begin
                        n_col = '0;
                        n_row = '0;
                    end
                    default: begin
                        n_col = r_col;
                        n_row = r_row;
                    end
                endcase
            end
        end
    end

    assign n_scrolled = i_cmd.exec ? o_status.need_scroll : r_scrolled;

    // store port selection
    always_comb begin
        w_we = 1'b0;
        w_wa = r_idx;
        w_wd = w_blank;
        if (i_cmd.exec && (r_op == tcw_pkg::OP_PUT_CHAR) && (r_ch != tcw_pkg::LINE_FEED)) begin
            w_we = 1'b1;
            w_wa = w_cur_lin[ADDR_W-1:0];
            w_wd = {w_attr, r_ch};
        end else if (r_mv_valid) begin
            w_we = 1'b1;
            w_wa = r_mv_addr;
            w_wd = r_rd_data;
        end else if (i_cmd.fill || i_cmd.clear) begin
            w_we = 1'b1;
        end
    end

    always_comb begin
        w_re = 1'b0;
        w_ra = r_idx + COLS_A;
        if (i_cmd.exec && (r_op == tcw_pkg::OP_READ_CELL) && w_target_ok) begin
            w_re = 1'b1;
            w_ra = w_tgt_lin[ADDR_W-1:0];
        end else if (i_cmd.move && (r_idx != MOVE_LAST)) begin
            w_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (w_re) r_rd_data <= r_mem[w_ra];
    end

    assign w_cell    = ((r_op == tcw_pkg::OP_READ_CELL) && w_target_ok) ? r_rd_data : '0;
    assign w_out_lin = lin_pos(n_row, n_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_s_tdata[2:0];
            r_ch   <= i_s_tdata[10:3];
            r_tcol <= i_s_tdata[17:11];
            r_trow <= i_s_tdata[22:18];
            r_ovr  <= i_s_tdata[23];
            r_ofg  <= i_s_tdata[27:24];
            r_obg  <= i_s_tdata[31:28];
        end
        if (i_cmd.load) begin
            r_out <= {n_scrolled, w_cell, w_out_lin[tcw_pkg::POS_W-1:0], n_row, n_col};
        end
        r_scrolled <= n_scrolled;
        r_mv_addr  <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_fg       <= tcw_pkg::FG_RESET;
            r_bg       <= tcw_pkg::BG_RESET;
            r_idx      <= '0;
            r_mv_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_mv_valid <= i_cmd.move && (r_idx != MOVE_LAST);
            if (i_cfg_we && (i_cfg_addr == tcw_pkg::CFG_FOREGROUND)) r_fg <= i_cfg_wdata;
            if (i_cfg_we && (i_cfg_addr == tcw_pkg::CFG_BACKGROUND)) r_bg <= i_cfg_wdata;
            if (i_cmd.exec) begin
                r_idx <= '0;
            end else if ((i_cmd.move && (r_idx != MOVE_LAST)) || i_cmd.fill || i_cmd.clear) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
        end
    end

    assign o_m_tdata = r_out;

endmodule

FILE: sv/text_console_writer.sv
`timescale 1ns / 1ps
// text_console_writer: top level of the text-mode console engine
// depends on tcw_pkg, tcw_ctrl and tcw_dp
//
//  channel   dir  handshake                 payload
//  s stream  in   i_s_tvalid / o_s_tready   i_s_tdata, 32 bits
//  m stream  out  o_m_tvalid / i_m_tready   o_m_tdata, 40 bits
//  config    in   i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// put_char without wrap to a scroll, newline, set_cursor and unused codes are taken
// in IDLE, then executed against the cursor and store in EXEC
// read_cell adds the READ state, for the registered read of the store
// a scroll adds the MOVE, FILL and DONE states: the store has a single write port, so
// rows move up one cell a cycle (read and write overlapped, the last write draining
// after the reads), then the bottom row fills, then DONE loads the result
// clear adds the CLEAR state, one blank written per cycle, then the result load in DONE
// the store has no reset; reset homes the cursor, resets colors and handshake state
// a finished result sits in the output register while the next request executes;
// only the hand-off of that next result waits on i_m_tready

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port: index 0 foreground, index 1 background
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_addr,
    input  logic [tcw_pkg::COLOR_W-1:0] i_cfg_wdata,
    // request stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [2:0] opcode, [10:3] char_code, [17:11] target_col, [22:18] target_row,
    // [23] use_override, [27:24] override_fg, [31:28] override_bg
    input  logic [tcw_pkg::IN_W-1:0]    i_s_tdata,
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_position,
    // [38:23] cell_data, [39] scrolled
    output logic [tcw_pkg::OUT_W-1:0]   o_m_tdata
);

    // command and status between sequencer and datapath
    tcw_pkg::t_cmd    w_cmd;
    tcw_pkg::t_status w_status;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

FILE: sv/tcw_checker.sv
`timescale 1ns / 1ps
// tcw_checker: port-level checks of the text console writer, bound to the top level
// depends on tcw_pkg

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [tcw_pkg::OUT_W-1:0] o_m_tdata
);

    logic [tcw_pkg::COL_W-1:0] w_col;
    logic [tcw_pkg::ROW_W-1:0] w_row;
    logic [tcw_pkg::POS_W-1:0] w_pos;
    logic                      w_scr;
    logic [15:0]               w_lin;

    assign w_col = o_m_tdata[6:0];
    assign w_row = o_m_tdata[11:7];
    assign w_pos = o_m_tdata[22:12];
    assign w_scr = o_m_tdata[39];
    assign w_lin = 16'(w_row) * 16'(COLUMNS) + 16'(w_col);

    // no result comes out of reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(w_col) < COLUMNS) && (32'(w_row) < ROWS))
        else $error("cursor out of range");

    a_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_pos == w_lin[tcw_pkg::POS_W-1:0])
        else $error("cursor position does not match row and column");

    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_scr |-> (w_col == '0) && (32'(w_row) == ROWS - 1))
        else $error("scroll left cursor off the last row start");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for the text console writer, with a shadow screen
// and cursor that predict every status word; depends on tcw_pkg and text_console_writer

module testbench;

    import tcw_pkg::*;

    localparam int COLUMNS    = COLUMNS_DEF;
    localparam int ROWS       = ROWS_DEF;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // opcodes the block leaves unused, they must only report the cursor
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam int              SPARE_COUNT    = 3;

    // runaway guard: worst case is every request a scroll plus long output stalls
    localparam int LIMIT_CYCLES  = 6_000_000;
    localparam int STALL_CYCLES  = 600;
    localparam int RANDOM_ITEMS  = 215;

    // request word, packed from the top so the opcode lands in the low bits
    typedef struct packed {
        logic [COLOR_W-1:0] override_bg;
        logic [COLOR_W-1:0] override_fg;
        logic               use_override;
        logic [ROW_W-1:0]   target_row;
        logic [COL_W-1:0]   target_col;
        logic [CHAR_W-1:0]  char_code;
        logic [OP_W-1:0]    opcode;
    } console_request_t;

    // status word returned for every request
    typedef struct packed {
        logic               scrolled;
        logic [CELL_W-1:0]  cell_data;
        logic [POS_W-1:0]   cursor_position;
        logic [ROW_W-1:0]   cursor_row;
        logic [COL_W-1:0]   cursor_col;
    } console_status_t;

    // clock, reset and everything driven into the block, known from time zero
    logic               i_clk     = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_addr  = CFG_FOREGROUND;
    logic [COLOR_W-1:0] cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic [IN_W-1:0]    s_tdata   = '0;
    logic               m_tready  = 1'b0;

    logic               o_s_tready;
    logic               o_m_tvalid;
    logic [OUT_W-1:0]   o_m_tdata;

    // shadow copy of the console: store, cursor and color registers
    logic [CELL_W-1:0]  shadow_screen [0:CELL_COUNT-1];
    int                 shadow_col = 0;
    int                 shadow_row = 0;
    logic [COLOR_W-1:0] fg_setting = FG_RESET;
    logic [COLOR_W-1:0] bg_setting = BG_RESET;

    // status words predicted for accepted requests, oldest first
    console_status_t    pending_status [$];

    // idle percentages of each side; the receiver one is read by its own process
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 100;
    // a nonzero value asks the receiver to hold off, loaded as its hold-off count
    int hold_request      = 0;
    int hold_left         = 0;

    int cycle_count    = 0;
    int error_count    = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int scroll_count   = 0;
    int clear_count    = 0;
    int read_count     = 0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        // [2:0] opcode, [10:3] char_code, [17:11] target_col, [22:18] target_row,
        // [23] use_override, [27:24] override_fg, [31:28] override_bg
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_position,
        // [38:23] cell_data, [39] scrolled
        .o_m_tdata   (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shadow console
    // ------------------------------------------------------------------

    // line feed: column home, then next row or scroll when already on the last row
    function automatic logic feed_line(input logic [CELL_W-1:0] blank_word);
        shadow_col = 0;
        if (shadow_row >= ROWS - 1) begin
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            end
            for (int c = 0; c < COLUMNS; c++) begin
                shadow_screen[(ROWS - 1) * COLUMNS + c] = blank_word;
            end
            shadow_row = ROWS - 1;
            return 1'b1;
        end
        shadow_row++;
        return 1'b0;
    endfunction

    // applies one request to the shadow console and returns its status word
    function automatic console_status_t update_console(input console_request_t req);
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [7:0]         attr;
        logic [CELL_W-1:0]  blank_word;
        console_status_t    res;
        res        = '0;
        fg         = req.use_override ? req.override_fg : fg_setting;
        bg         = req.use_override ? req.override_bg : bg_setting;
        attr       = {bg, fg};
        blank_word = {attr, BLANK_CHAR};
        case (req.opcode)
            OP_PUT_CHAR: begin
                if (req.char_code == LINE_FEED) begin
                    res.scrolled = feed_line(blank_word);
                end else begin
                    shadow_screen[shadow_row * COLUMNS + shadow_col] = {attr, req.char_code};
                    shadow_col++;
                    // running off the row end behaves like a line feed
                    if (shadow_col >= COLUMNS) begin
                        res.scrolled = feed_line(blank_word);
                    end
                end
            end
            OP_NEWLINE: begin
                res.scrolled = feed_line(blank_word);
            end
            OP_SET_CURSOR: begin
                // out of range positions leave the cursor alone
                if (req.target_col < COLUMNS && req.target_row < ROWS) begin
                    shadow_col = req.target_col;
                    shadow_row = req.target_row;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++) begin
                    shadow_screen[i] = blank_word;
                end
                shadow_col = 0;
                shadow_row = 0;
            end
            OP_READ_CELL: begin
                // out of range reads return zero
                if (req.target_col < COLUMNS && req.target_row < ROWS) begin
                    res.cell_data = shadow_screen[req.target_row * COLUMNS + req.target_col];
                end
            end
            default: begin
            end
        endcase
        res.cursor_col      = COL_W'(shadow_col);
        res.cursor_row      = ROW_W'(shadow_row);
        res.cursor_position = POS_W'(shadow_row * COLUMNS + shadow_col);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // receiver: random back-pressure, plus long hold-offs on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    <= hold_request;
            hold_request <= 0;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // status checker: every handed-off word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        console_status_t got;
        console_status_t want;
        if (rst_n && o_m_tvalid && m_tready) begin
            got = o_m_tdata;
            results_seen++;
            if (pending_status.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected status word %h with no request outstanding", got);
                end
            end else begin
                want = pending_status.pop_front();
                if (got.cursor_col !== want.cursor_col
                        || got.cursor_row !== want.cursor_row
                        || got.cursor_position !== want.cursor_position
                        || got.cell_data !== want.cell_data
                        || got.scrolled !== want.scrolled) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("status %0d mismatch: col %0d/%0d row %0d/%0d pos %0d/%0d",
                                 results_seen, got.cursor_col, want.cursor_col,
                                 got.cursor_row, want.cursor_row,
                                 got.cursor_position, want.cursor_position);
                        $display("    cell %h/%h scrolled %b/%b (got/expected)",
                                 got.cell_data, want.cell_data, got.scrolled, want.scrolled);
                    end
                end
            end
        end
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d status words outstanding",
                     cycle_count, pending_status.size());
            $display("FAIL text_console_writer");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offers one request, with random idle cycles ahead of it, and predicts its status;
    // tvalid is left high so a following request goes out back to back
    task automatic send_request(input console_request_t req);
        console_status_t want;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        want = update_console(req);
        pending_status.push_back(want);
        requests_sent++;
        if (want.scrolled) begin
            scroll_count++;
        end
        if (req.opcode == OP_CLEAR) begin
            clear_count++;
        end
        if (req.opcode == OP_READ_CELL) begin
            read_count++;
        end
    endtask

    // builds and sends a request from its fields
    task automatic send_fields(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                               input int col, input int row, input logic ovr,
                               input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        console_request_t req;
        req.opcode       = op;
        req.char_code    = ch;
        req.target_col   = COL_W'(col);
        req.target_row   = ROW_W'(row);
        req.use_override = ovr;
        req.override_fg  = fg;
        req.override_bg  = bg;
        send_request(req);
    endtask

    // stops offering and waits until every predicted status word has come back
    task automatic drain_status();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_status.size() != 0);
    endtask

    // color register write; only called while the block is idle
    task automatic write_color(input logic idx, input logic [COLOR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FOREGROUND) begin
            fg_setting = value;
        end else begin
            bg_setting = value;
        end
    endtask

    // random request: all fields random, then the opcode and position shaped so
    // the cursor often sits at row ends and on the last row, where wraps and scrolls happen
    function automatic console_request_t random_request();
        console_request_t req;
        int               pick;
        req  = console_request_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            req.opcode = OP_PUT_CHAR;
            if ($urandom_range(0, 19) == 0) begin
                req.char_code = LINE_FEED;
            end
        end else if (pick < 54) begin
            req.opcode = OP_NEWLINE;
        end else if (pick < 70) begin
            req.opcode = OP_SET_CURSOR;
        end else if (pick < 90) begin
            req.opcode = OP_READ_CELL;
        end else if (pick < 91) begin
            req.opcode = OP_CLEAR;
        end else if (pick < 94) begin
            req.opcode = OP_SPARE_FIRST + OP_W'($urandom_range(0, SPARE_COUNT - 1));
        end else begin
            req.opcode = OP_PUT_CHAR;
        end
        if (req.opcode == OP_SET_CURSOR || req.opcode == OP_READ_CELL) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                // off the screen in one coordinate or the other
                if ($urandom_range(0, 1)) begin
                    req.target_col = COL_W'($urandom_range(COLUMNS, (1 << COL_W) - 1));
                end else begin
                    req.target_row = ROW_W'($urandom_range(ROWS, (1 << ROW_W) - 1));
                end
            end else begin
                req.target_col = COL_W'($urandom_range(0, COLUMNS - 1));
                req.target_row = ROW_W'($urandom_range(0, ROWS - 1));
                if (pick < 45) begin
                    req.target_col = COL_W'($urandom_range(COLUMNS - 4, COLUMNS - 1));
                end
                if (pick >= 35 && pick < 70) begin
                    req.target_row = ROW_W'(ROWS - 1);
                end
            end
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked requests: field extremes, every opcode, wraps, scrolls and
    // out of range positions; a clear comes first so every cell is written before a read
    task automatic test_directed_cases();
        sender_idle_pct   = 6;
        receiver_idle_pct <= 71;
        send_fields(OP_CLEAR,      8'h00, 0, 0, 1'b0, 4'h0, 4'h0);
        send_fields(OP_PUT_CHAR,   8'h00, 0, 0, 1'b1, 4'h0, 4'h0);
        send_fields(OP_PUT_CHAR,   8'hFF, 0, 0, 1'b1, 4'hF, 4'hF);
        send_fields(OP_PUT_CHAR,   8'h41, 0, 0, 1'b0, 4'h0, 4'h0);
        send_fields(OP_PUT_CHAR,   LINE_FEED, 0, 0, 1'b0, 4'h0, 4'h0);
        send_fields(OP_NEWLINE,    8'h00, 0, 0, 1'b0, 4'h0, 4'h0);
        // wrap at the row end, not on the last row
        send_fields(OP_SET_CURSOR, 8'h00, COLUMNS - 1, 0, 1'b0, 4'h0, 4'h0);
        send_fields(OP_PUT_CHAR,   8'h5A, 0, 0, 1'b0, 4'h0, 4'h0);
        // wrap on the last row scrolls
        send_fields(OP_SET_CURSOR, 8'h00, COLUMNS - 1, ROWS - 1, 1'b0, 4'h0, 4'h0);
        send_fields(OP_PUT_CHAR,   8'h51, 0, 0, 1'b1, 4'h3, 4'hC);
        send_fields(OP_READ_CELL,  8'h00, COLUMNS - 1, ROWS - 2, 1'b0, 4'h0, 4'h0);
        send_fields(OP_READ_CELL,  8'h00, 0, ROWS - 1, 1'b0, 4'h0, 4'h0);
        send_fields(OP_READ_CELL,  8'h00, 0, 0, 1'b0, 4'h0, 4'h0);
        // positions off the screen
        send_fields(OP_SET_CURSOR, 8'h00, COLUMNS, 0, 1'b0, 4'h0, 4'h0);
        send_fields(OP_SET_CURSOR, 8'h00, 0, ROWS, 1'b0, 4'h0, 4'h0);
        send_fields(OP_SET_CURSOR, 8'h00, (1 << COL_W) - 1, (1 << ROW_W) - 1,
                    1'b0, 4'h0, 4'h0);
        send_fields(OP_READ_CELL,  8'h00, COLUMNS, 0, 1'b0, 4'h0, 4'h0);
        send_fields(OP_READ_CELL,  8'h00, 0, ROWS, 1'b0, 4'h0, 4'h0);
        send_fields(OP_READ_CELL,  8'h00, (1 << COL_W) - 1, (1 << ROW_W) - 1,
                    1'b0, 4'h0, 4'h0);
        // newline while on the last row scrolls again
        send_fields(OP_NEWLINE,    8'h00, 0, 0, 1'b1, 4'hF, 4'h0);
        for (int k = 0; k < SPARE_COUNT; k++) begin
            send_fields(OP_SPARE_FIRST + OP_W'(k), 8'hFF, (1 << COL_W) - 1,
                        (1 << ROW_W) - 1, 1'b1, 4'hF, 4'hF);
        end
        send_fields(OP_CLEAR,      8'h00, 0, 0, 1'b1, 4'hF, 4'hF);
        send_fields(OP_READ_CELL,  8'h00, COLUMNS - 1, ROWS - 1, 1'b0, 4'h0, 4'h0);
        drain_status();
    endtask

    // long output stall while requests keep coming, so the block fills and
    // drops its tready; then the sender pauses until everything is back
    task automatic test_output_stall();
        sender_idle_pct = 0;
        hold_request <= STALL_CYCLES;
        for (int k = 0; k < 30; k++) begin
            send_request(random_request());
        end
        drain_status();
    endtask

    // random traffic under one idle mix and one color setting
    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [COLOR_W-1:0] fg,
                                       input logic [COLOR_W-1:0] bg, input int count);
        drain_status();
        write_color(CFG_FOREGROUND, fg);
        write_color(CFG_BACKGROUND, bg);
        sender_idle_pct   = tx_pct;
        receiver_idle_pct <= rx_pct;
        for (int k = 0; k < count; k++) begin
            send_request(random_request());
        end
        drain_status();
    endtask

    initial begin
        // shadow store holds zeros until the first clear, which comes before any read
        for (int i = 0; i < CELL_COUNT; i++) begin
            shadow_screen[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_output_stall();
        // color extremes in the first two phases, random colors in the last
        test_random_traffic(6, 71, 4'h0, 4'hF, RANDOM_ITEMS);
        test_random_traffic(71, 6, 4'hF, 4'h0, RANDOM_ITEMS);
        test_random_traffic(0, 0, COLOR_W'($urandom), COLOR_W'($urandom), RANDOM_ITEMS);

        // room for a stray late word: longer than a full clear or scroll
        repeat (CELL_COUNT + 16) @(posedge i_clk);
        if (pending_status.size() != 0) begin
            error_count++;
            $display("%0d status words never arrived", pending_status.size());
        end

        $display("sent %0d requests (%0d scrolls, %0d clears, %0d reads), checked %0d words",
                 requests_sent, scroll_count, clear_count, read_count, results_seen);
        $display("idle mixes sender/receiver 6/71, 71/6, 0/0, plus a %0d cycle output stall",
                 STALL_CYCLES);
        if (error_count == 0) begin
            $display("PASS text_console_writer");
        end else begin
            $display("%0d failures", error_count);
            $display("FAIL text_console_writer");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_dp.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
tb/sv/testbench.sv
